[hdl/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ITOA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ITOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/itoa_pkg.sv]
// Package: widths, ASCII codes and digit helpers for the integer-to-text converter.
`timescale 1ns / 1ps
`default_nettype none
package itoa_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned LimitWidth  = 8;
  localparam int unsigned CharWidth   = 7;
  localparam int unsigned DecDigits   = 10;
  localparam int unsigned HexDigits   = ValueWidth / 4;
  localparam int unsigned BcdWidth    = 4 * DecDigits;
  localparam int unsigned BitCntWidth = $clog2(ValueWidth);
  localparam int unsigned DigCntWidth = $clog2(DecDigits + 1);

  localparam logic [CharWidth-1:0] AsciiZero  = 7'h30;
  localparam logic [CharWidth-1:0] AsciiLowA  = 7'h61;
  localparam logic [CharWidth-1:0] AsciiLowF  = 7'h66;
  localparam logic [CharWidth-1:0] AsciiNine  = 7'h39;
  localparam logic [CharWidth-1:0] AsciiMinus = 7'h2d;

  // One digit value (0..15) to its lower-case ASCII character.
  function automatic logic [CharWidth-1:0] digit_to_ascii(input logic [3:0] dig);
    logic [CharWidth-1:0] code;
    if (dig < 4'd10) begin
      code = AsciiZero + {3'b000, dig};
    end else begin
      code = AsciiLowA + {3'b000, dig} - 7'd10;
    end
    return code;
  endfunction

  // Double-dabble correction: add 3 to every BCD digit of 5 or more.
  function automatic logic [BcdWidth-1:0] bcd_adjust(input logic [BcdWidth-1:0] bcd);
    logic [BcdWidth-1:0] res;
    res = bcd;
    for (int i = 0; i < DecDigits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[hdl/int_to_ascii_converter.sv]
// Top level: converts a 32-bit word to decimal or hex ASCII text, one character per output transfer.
//
//  channel | direction | fields                            | flow
//  --------+-----------+-----------------------------------+----------------------
//  in      | to block  | req_type_i, value_i, max_chars_i  | in_valid_i/in_ready_o
//  out     | from block| char_code_o, last_o               | out_valid_o/out_ready_i
//
// Decimal: the magnitude is shifted into a 10-digit BCD register one bit per cycle
// (double dabble). Hex loads its 8 nibbles directly. Leading zeros drop one nibble
// per cycle, then one character per cycle leaves through the output register while
// the output is not stalled.
// The next request is taken once the final character sits in the output register.
// Reset clears the state machine and the output valid; a stalled output holds the block.
`timescale 1ns / 1ps
`default_nettype none
module int_to_ascii_converter (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire                                 req_type_i,
  input  wire  [itoa_pkg::ValueWidth-1:0]     value_i,
  input  wire  [itoa_pkg::LimitWidth-1:0]     max_chars_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [itoa_pkg::CharWidth-1:0]      char_code_o,
  output logic                                last_o
);
  import itoa_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSkip,
    StEmit
  } state_e;

  state_e                 state_q, state_d;
  logic [ValueWidth-1:0]  mag_q, mag_d;
  logic [BcdWidth-1:0]    bcd_q, bcd_d;
  logic [BitCntWidth-1:0] bitcnt_q, bitcnt_d;
  logic [DigCntWidth-1:0] ndig_q, ndig_d;
  logic [LimitWidth-1:0]  lim_q, lim_d;
  logic                   sign_q, sign_d;
  logic                   out_valid_q, out_valid_d;
  logic [CharWidth-1:0]   char_q, char_d;
  logic                   last_q, last_d;

  logic                   in_fire;
  logic                   slot_free;
  logic                   neg;
  logic [BcdWidth-1:0]    bcd_adj;
  logic [3:0]             top_dig;
  logic                   emit_last;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign neg         = !req_type_i && value_i[ValueWidth-1];
  assign bcd_adj     = bcd_adjust(bcd_q);
  assign top_dig     = bcd_q[BcdWidth-1 -: 4];

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

  // Next-state and datapath
  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    bitcnt_d    = bitcnt_q;
    ndig_d      = ndig_q;
    lim_d       = lim_q;
    sign_d      = sign_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    emit_last   = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_fire && (max_chars_i != '0)) begin
          sign_d   = neg;
          mag_d    = neg ? (ValueWidth'(0) - value_i) : value_i;
          lim_d    = max_chars_i;
          bitcnt_d = '0;
          if (req_type_i) begin
            bcd_d   = {value_i, {(BcdWidth - ValueWidth){1'b0}}};
            ndig_d  = DigCntWidth'(HexDigits);
            state_d = StSkip;
          end else begin
            bcd_d   = '0;
            ndig_d  = DigCntWidth'(DecDigits);
            state_d = StConv;
          end
        end
      end

      // One magnitude bit per cycle into the BCD register
      StConv: begin
        bcd_d    = {bcd_adj[BcdWidth-2:0], mag_q[ValueWidth-1]};
        mag_d    = {mag_q[ValueWidth-2:0], 1'b0};
        bitcnt_d = bitcnt_q + BitCntWidth'(1);
        if (bitcnt_q == BitCntWidth'(ValueWidth - 1)) begin
          state_d = StSkip;
        end
      end

      // Drop leading zero digits, keep at least one
      StSkip: begin
        if ((ndig_q > DigCntWidth'(1)) && (top_dig == 4'd0)) begin
          bcd_d  = {bcd_q[BcdWidth-5:0], 4'd0};
          ndig_d = ndig_q - DigCntWidth'(1);
        end else begin
          state_d = StEmit;
        end
      end

      // Sign first, then digits, most significant first
      StEmit: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          lim_d       = lim_q - LimitWidth'(1);
          if (sign_q) begin
            char_d    = AsciiMinus;
            sign_d    = 1'b0;
            emit_last = (lim_q == LimitWidth'(1));
          end else begin
            char_d    = digit_to_ascii(top_dig);
            bcd_d     = {bcd_q[BcdWidth-5:0], 4'd0};
            ndig_d    = ndig_q - DigCntWidth'(1);
            emit_last = (lim_q == LimitWidth'(1)) || (ndig_q == DigCntWidth'(1));
          end
          last_d = emit_last;
          if (emit_last) begin
            state_d = StIdle;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mag_q       <= '0;
      bcd_q       <= '0;
      bitcnt_q    <= '0;
      ndig_q      <= '0;
      lim_q       <= '0;
      sign_q      <= 1'b0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      mag_q       <= mag_d;
      bcd_q       <= bcd_d;
      bitcnt_q    <= bitcnt_d;
      ndig_q      <= ndig_d;
      lim_q       <= lim_d;
      sign_q      <= sign_d;
      out_valid_q <= out_valid_d;
      char_q      <= char_d;
      last_q      <= last_d;
    end
  end

endmodule
`default_nettype wire

[hdl/itoa_checker.sv]
// Port-level checker for the integer-to-text converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module itoa_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             in_valid_i,
  input wire                             in_ready_o,
  input wire  [itoa_pkg::LimitWidth-1:0] max_chars_i,
  input wire                             out_valid_o,
  input wire                             out_ready_i,
  input wire  [itoa_pkg::CharWidth-1:0]  char_code_o,
  input wire                             last_o
);
  import itoa_pkg::*;

  // A stalled character holds
  `ITOA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(char_code_o) && $stable(last_o), "output changed while stalled")

  // A request with a nonzero limit keeps the block busy
  `ITOA_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o && (max_chars_i != '0), !in_ready_o, "ready stayed high after a nonzero request")

  // A zero limit produces nothing and the block stays free
  `ITOA_ASSERT_NEXT(a_zero_limit, in_valid_i && in_ready_o && (max_chars_i == '0), in_ready_o, "zero-limit request took the block")

  // Only sign, decimal digits and a-f ever leave
  `ITOA_ASSERT_NOW(a_char_set, out_valid_o, (char_code_o == AsciiMinus) || ((char_code_o >= AsciiZero) && (char_code_o <= AsciiNine)) || ((char_code_o >= AsciiLowA) && (char_code_o <= AsciiLowF)), "illegal character code")

endmodule

bind int_to_ascii_converter itoa_checker u_itoa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .max_chars_i (max_chars_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .char_code_o (char_code_o),
  .last_o      (last_o)
);
`default_nettype wire
